// ----- rtl/core/multi_task_heartbeat_watchdog_defines.svh -----
// Assertion macros for the heartbeat watchdog checker
`ifndef MULTI_TASK_HEARTBEAT_WATCHDOG_DEFINES_SVH
`define MULTI_TASK_HEARTBEAT_WATCHDOG_DEFINES_SVH

// same-cycle implication, quiet during reset
`define MTHW_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mthw assertion failed");

// next-cycle implication, quiet during reset
`define MTHW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mthw assertion failed");

// next-cycle implication, checked through reset as well
`define MTHW_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("mthw assertion failed");

`endif

// ----- rtl/core/mthw_pkg.sv -----
// Types and constants shared by the heartbeat watchdog modules
`timescale 1ns / 1ps
package mthw_pkg;

    localparam int NUM_TASKS = 7;
    localparam int TASK_W    = 3;
    localparam int REG_IDX_W = 3;
    localparam int ADDR_W    = REG_IDX_W + 2;

    localparam logic [TASK_W-1:0] NO_TASK = 3'd7;

    localparam logic [1:0] OP_BOOT      = 2'd0;
    localparam logic [1:0] OP_HEARTBEAT = 2'd1;
    localparam logic [1:0] OP_CHECK     = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_WDT_ENABLE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RADIO_STALE    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BEACON_STALE   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_POLL_STALE     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_WEATHER_STALE  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_CONSOLE_STALE  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_MAX_REBOOTS    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_HEALTHY_UPTIME = 3'd7;

    localparam logic [31:0] RST_RADIO_STALE    = 32'd90000;
    localparam logic [31:0] RST_BEACON_STALE   = 32'd30000;
    localparam logic [31:0] RST_POLL_STALE     = 32'd15000;
    localparam logic [31:0] RST_WEATHER_STALE  = 32'd30000;
    localparam logic [31:0] RST_CONSOLE_STALE  = 32'd10000;
    localparam logic [7:0]  RST_MAX_REBOOTS    = 8'd5;
    localparam logic [31:0] RST_HEALTHY_UPTIME = 32'd300000;

    localparam logic [7:0] COUNT_MAX = 8'd255;

    typedef struct packed {
        logic        wdt_enable;
        logic [31:0] radio_stale;
        logic [31:0] beacon_stale;
        logic [31:0] poll_stale;
        logic [31:0] weather_stale;
        logic [31:0] console_stale;
        logic [7:0]  max_reboots;
        logic [31:0] healthy_uptime;
    } t_cfg;

    typedef struct packed {
        logic              clr;
        logic              wr;
        logic [TASK_W-1:0] task_id;
        logic [31:0]       now;
    } t_tbl_req;

    typedef struct packed {
        logic              all_alive;
        logic [TASK_W-1:0] stale_task;
    } t_tbl_rsp;

    function automatic logic [31:0] limit_of(input t_cfg cfg, input logic [TASK_W-1:0] idx);
        logic [31:0] lim;
        unique case (idx)
            3'd0, 3'd1: lim = cfg.radio_stale;
            3'd2:       lim = cfg.beacon_stale;
            3'd3, 3'd4: lim = cfg.poll_stale;
            3'd5:       lim = cfg.weather_stale;
            default:    lim = cfg.console_stale;
        endcase
        return lim;
    endfunction

endpackage

// ----- rtl/core/mthw_cfg_regs.sv -----
// APB configuration registers of the heartbeat watchdog
`timescale 1ns / 1ps
module mthw_cfg_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mthw_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output mthw_pkg::t_cfg              o_cfg
);
    import mthw_pkg::*;

    t_cfg                 r_cfg;
    t_cfg                 n_cfg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_WDT_ENABLE:     n_cfg.wdt_enable     = pwdata[0];
                REG_RADIO_STALE:    n_cfg.radio_stale    = pwdata;
                REG_BEACON_STALE:   n_cfg.beacon_stale   = pwdata;
                REG_POLL_STALE:     n_cfg.poll_stale     = pwdata;
                REG_WEATHER_STALE:  n_cfg.weather_stale  = pwdata;
                REG_CONSOLE_STALE:  n_cfg.console_stale  = pwdata;
                REG_MAX_REBOOTS:    n_cfg.max_reboots    = pwdata[7:0];
                REG_HEALTHY_UPTIME: n_cfg.healthy_uptime = pwdata;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_WDT_ENABLE:     prdata = {31'd0, r_cfg.wdt_enable};
            REG_RADIO_STALE:    prdata = r_cfg.radio_stale;
            REG_BEACON_STALE:   prdata = r_cfg.beacon_stale;
            REG_POLL_STALE:     prdata = r_cfg.poll_stale;
            REG_WEATHER_STALE:  prdata = r_cfg.weather_stale;
            REG_CONSOLE_STALE:  prdata = r_cfg.console_stale;
            REG_MAX_REBOOTS:    prdata = {24'd0, r_cfg.max_reboots};
            REG_HEALTHY_UPTIME: prdata = r_cfg.healthy_uptime;
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.wdt_enable     <= 1'b1;
            r_cfg.radio_stale    <= RST_RADIO_STALE;
            r_cfg.beacon_stale   <= RST_BEACON_STALE;
            r_cfg.poll_stale     <= RST_POLL_STALE;
            r_cfg.weather_stale  <= RST_WEATHER_STALE;
            r_cfg.console_stale  <= RST_CONSOLE_STALE;
            r_cfg.max_reboots    <= RST_MAX_REBOOTS;
            r_cfg.healthy_uptime <= RST_HEALTHY_UPTIME;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/mthw_task_table.sv -----
// Heartbeat timestamps of the seven tasks and the first-stale search
`timescale 1ns / 1ps
module mthw_task_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mthw_pkg::t_cfg     i_cfg,
    input  mthw_pkg::t_tbl_req i_req,
    output mthw_pkg::t_tbl_rsp o_rsp
);
    import mthw_pkg::*;

    logic [31:0]          r_last_seen [NUM_TASKS];
    logic [31:0]          n_last_seen [NUM_TASKS];
    logic [31:0]          age         [NUM_TASKS];
    logic [NUM_TASKS-1:0] stale_vec;
    logic [TASK_W-1:0]    first_stale;

    always_comb begin
        for (int i = 0; i < NUM_TASKS; i++) begin
            n_last_seen[i] = r_last_seen[i];
            if (i_req.clr) begin
                n_last_seen[i] = 32'd0;
            end else if (i_req.wr && i_req.task_id == TASK_W'(i)) begin
                n_last_seen[i] = i_req.now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_last_seen[i] <= 32'd0;
            end
        end else begin
            for (int i = 0; i < NUM_TASKS; i++) begin
                r_last_seen[i] <= n_last_seen[i];
            end
        end
    end

    // zero stamp: task never started, never stale
    always_comb begin
        for (int i = 0; i < NUM_TASKS; i++) begin
            age[i]       = i_req.now - r_last_seen[i];
            stale_vec[i] = (r_last_seen[i] != 32'd0)
                && (age[i] > limit_of(i_cfg, TASK_W'(i)));
        end
    end

    always_comb begin
        first_stale = NO_TASK;
        for (int i = NUM_TASKS - 1; i >= 0; i--) begin
            if (stale_vec[i]) begin
                first_stale = TASK_W'(i);
            end
        end
    end

    assign o_rsp.stale_task = first_stale;
    assign o_rsp.all_alive  = ~|stale_vec;

endmodule

// ----- rtl/core/mthw_core.sv -----
// Input register, boot and health state, and result register
`timescale 1ns / 1ps
module mthw_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_opcode,
    input  logic [mthw_pkg::TASK_W-1:0] i_task_id,
    input  logic [31:0]                 i_now_ms,
    input  logic                        i_was_watchdog_reset,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_feed,
    output logic                        o_armed,
    output logic                        o_all_alive,
    output logic [mthw_pkg::TASK_W-1:0] o_stale_task,
    output logic [7:0]                  o_wdt_reboots,
    output logic                        o_healthy_reached,
    input  mthw_pkg::t_cfg              i_cfg,
    output mthw_pkg::t_tbl_req          o_tbl_req,
    input  mthw_pkg::t_tbl_rsp          i_tbl_rsp
);
    import mthw_pkg::*;

    logic              r_in_valid;
    logic [1:0]        r_in_opcode;
    logic [TASK_W-1:0] r_in_task_id;
    logic [31:0]       r_in_now;
    logic              r_in_wdt_reset;

    logic [7:0]        r_count;
    logic [7:0]        n_count;
    logic              r_armed;
    logic              n_armed;
    logic              r_healthy;
    logic              n_healthy;
    logic [31:0]       r_boot_time;
    logic [31:0]       n_boot_time;

    logic              r_out_valid;
    logic              r_out_feed;
    logic              r_out_all_alive;
    logic [TASK_W-1:0] r_out_stale_task;

    logic              stage_go;
    logic              res_feed;
    logic              res_alive;
    logic [TASK_W-1:0] res_stale;
    logic [7:0]        boot_count;
    logic [31:0]       uptime;

    assign stage_go   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || stage_go;
    assign uptime     = r_in_now - r_boot_time;

    always_comb begin
        boot_count = r_count;
        if (!r_in_wdt_reset) begin
            boot_count = 8'd0;
        end else if (r_count != COUNT_MAX) begin
            boot_count = r_count + 8'd1;
        end
    end

    always_comb begin
        n_count     = r_count;
        n_armed     = r_armed;
        n_healthy   = r_healthy;
        n_boot_time = r_boot_time;
        res_feed    = 1'b0;
        res_alive   = 1'b0;
        res_stale   = NO_TASK;
        unique case (r_in_opcode)
            OP_BOOT: begin
                n_boot_time = r_in_now;
                n_healthy   = 1'b0;
                if (i_cfg.wdt_enable) begin
                    n_count = boot_count;
                    n_armed = (boot_count <= i_cfg.max_reboots);
                end else begin
                    n_armed = 1'b0;
                end
            end
            OP_CHECK: begin
                res_alive = i_tbl_rsp.all_alive;
                res_stale = i_tbl_rsp.stale_task;
                res_feed  = r_armed && i_tbl_rsp.all_alive;
                if (res_feed && !r_healthy && uptime >= i_cfg.healthy_uptime) begin
                    n_healthy = 1'b1;
                    n_count   = 8'd0;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    assign o_tbl_req.clr     = stage_go && (r_in_opcode == OP_BOOT);
    assign o_tbl_req.wr      = stage_go && (r_in_opcode == OP_HEARTBEAT);
    assign o_tbl_req.task_id = r_in_task_id;
    assign o_tbl_req.now     = r_in_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_opcode    <= i_opcode;
            r_in_task_id   <= i_task_id;
            r_in_now       <= i_now_ms;
            r_in_wdt_reset <= i_was_watchdog_reset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= 8'd0;
            r_armed     <= 1'b0;
            r_healthy   <= 1'b0;
            r_boot_time <= 32'd0;
        end else if (stage_go) begin
            r_count     <= n_count;
            r_armed     <= n_armed;
            r_healthy   <= n_healthy;
            r_boot_time <= n_boot_time;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (stage_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_go) begin
            r_out_feed       <= res_feed;
            r_out_all_alive  <= res_alive;
            r_out_stale_task <= res_stale;
        end
    end

    // armed, count and healthy mirror state, which only moves with the result register
    assign o_out_valid       = r_out_valid;
    assign o_feed            = r_out_feed;
    assign o_armed           = r_armed;
    assign o_all_alive       = r_out_all_alive;
    assign o_stale_task      = r_out_stale_task;
    assign o_wdt_reboots     = r_count;
    assign o_healthy_reached = r_healthy;

endmodule

// ----- rtl/core/multi_task_heartbeat_watchdog.sv -----
// The result of an item is registered after acceptance, once the output is not stalled
// (input register, combinational evaluation, result register).
// Throughput: one item per cycle unless stalled; seven 32-bit age compares set the cycle.
// Reset (synchronous, active low): timestamps, reboot count, armed, healthy and boot time
// clear, both registers empty, configuration returns to its defaults.
`timescale 1ns / 1ps
module multi_task_heartbeat_watchdog (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_opcode,
    input  logic [mthw_pkg::TASK_W-1:0] i_task_id,
    input  logic [31:0]                 i_now_ms,
    input  logic                        i_was_watchdog_reset,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_feed,
    output logic                        o_armed,
    output logic                        o_all_alive,
    output logic [mthw_pkg::TASK_W-1:0] o_stale_task,
    output logic [7:0]                  o_wdt_reboots,
    output logic                        o_healthy_reached,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mthw_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import mthw_pkg::*;

    t_cfg     cfg;
    t_tbl_req tbl_req;
    t_tbl_rsp tbl_rsp;

    assign pready = 1'b1;

    mthw_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (cfg)
    );

    mthw_task_table u_task_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_req   (tbl_req),
        .o_rsp   (tbl_rsp)
    );

    mthw_core u_core (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_opcode             (i_opcode),
        .i_task_id            (i_task_id),
        .i_now_ms             (i_now_ms),
        .i_was_watchdog_reset (i_was_watchdog_reset),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_feed               (o_feed),
        .o_armed              (o_armed),
        .o_all_alive          (o_all_alive),
        .o_stale_task         (o_stale_task),
        .o_wdt_reboots        (o_wdt_reboots),
        .o_healthy_reached    (o_healthy_reached),
        .i_cfg                (cfg),
        .o_tbl_req            (tbl_req),
        .i_tbl_rsp            (tbl_rsp)
    );

endmodule

// ----- rtl/core/mthw_checker.sv -----
// Port-level checker for the heartbeat watchdog and its bind
`timescale 1ns / 1ps
`include "multi_task_heartbeat_watchdog_defines.svh"
module mthw_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_out_ready,
    input logic                        o_out_valid,
    input logic                        o_feed,
    input logic                        o_armed,
    input logic                        o_all_alive,
    input logic [mthw_pkg::TASK_W-1:0] o_stale_task,
    input logic [7:0]                  o_wdt_reboots,
    input logic                        o_healthy_reached
);
    import mthw_pkg::*;

    logic [TASK_W+7:0] held_fields;

    assign held_fields = {o_stale_task, o_wdt_reboots};

    `MTHW_ASSERT_IMPL(a_feed_needs_alive_armed, o_out_valid && o_feed, o_all_alive && o_armed)
    `MTHW_ASSERT_IMPL(a_alive_no_stale, o_out_valid && o_all_alive, o_stale_task == NO_TASK)
    `MTHW_ASSERT_IMPL(a_healthy_clears, o_out_valid && o_healthy_reached, o_wdt_reboots == 8'd0)
    `MTHW_ASSERT_RST(a_reset_empties_output, !i_rst_n, !o_out_valid)
    `MTHW_ASSERT_NEXT(a_stall_holds, o_out_valid && !i_out_ready, o_out_valid && $stable(held_fields))

endmodule

bind multi_task_heartbeat_watchdog mthw_checker u_mthw_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_ready       (i_out_ready),
    .o_out_valid       (o_out_valid),
    .o_feed            (o_feed),
    .o_armed           (o_armed),
    .o_all_alive       (o_all_alive),
    .o_stale_task      (o_stale_task),
    .o_wdt_reboots     (o_wdt_reboots),
    .o_healthy_reached (o_healthy_reached)
);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the multi-task heartbeat watchdog, with its own status predictor
`timescale 1ns / 1ps
module tb_top;
    import mthw_pkg::*;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam int STALL_LIMIT = 4000;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic              feed;
        logic              armed;
        logic              all_alive;
        logic [TASK_W-1:0] stale_task;
        logic [7:0]        wdt_reboots;
        logic              healthy;
    } t_wd_status;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic [1:0]        in_opcode = OP_RESERVED;
    logic [TASK_W-1:0] in_task_id = '0;
    logic [31:0]       in_now_ms = '0;
    logic              in_wdr = 1'b0;
    logic              out_ready = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;

    logic              o_in_ready;
    logic              o_out_valid;
    logic              o_feed;
    logic              o_armed;
    logic              o_all_alive;
    logic [TASK_W-1:0] o_stale_task;
    logic [7:0]        o_wdt_reboots;
    logic              o_healthy_reached;
    logic [31:0]       prdata;
    logic              pready;

    t_cfg        cfg_now;
    logic [31:0] seen_ms [NUM_TASKS];
    logic [7:0]  reboots;
    logic        armed_now;
    logic [31:0] boot_ms;
    logic        healthy_now;

    t_wd_status  status_q [$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic [31:0] clock_ms = '0;

    multi_task_heartbeat_watchdog dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (in_valid),
        .o_in_ready           (o_in_ready),
        .i_opcode             (in_opcode),
        .i_task_id            (in_task_id),
        .i_now_ms             (in_now_ms),
        .i_was_watchdog_reset (in_wdr),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (out_ready),
        .o_feed               (o_feed),
        .o_armed              (o_armed),
        .o_all_alive          (o_all_alive),
        .o_stale_task         (o_stale_task),
        .o_wdt_reboots        (o_wdt_reboots),
        .o_healthy_reached    (o_healthy_reached),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [31:0] task_age_limit(input int t);
        logic [31:0] lim;
        case (t)
            0, 1:    lim = cfg_now.radio_stale;
            2:       lim = cfg_now.beacon_stale;
            3, 4:    lim = cfg_now.poll_stale;
            5:       lim = cfg_now.weather_stale;
            default: lim = cfg_now.console_stale;
        endcase
        return lim;
    endfunction

    function automatic t_wd_status supervise_step(input logic [1:0] op,
                                                  input logic [TASK_W-1:0] tid,
                                                  input logic [31:0] now,
                                                  input logic wdr);
        t_wd_status  st;
        logic [31:0] age;
        st.feed       = 1'b0;
        st.all_alive  = 1'b0;
        st.stale_task = NO_TASK;
        case (op)
            OP_BOOT: begin
                for (int i = 0; i < NUM_TASKS; i++) seen_ms[i] = '0;
                boot_ms     = now;
                healthy_now = 1'b0;
                if (cfg_now.wdt_enable) begin
                    if (wdr) begin
                        if (reboots != COUNT_MAX) reboots = reboots + 8'd1;
                    end else begin
                        reboots = '0;
                    end
                    armed_now = (reboots <= cfg_now.max_reboots);
                end else begin
                    armed_now = 1'b0;
                end
            end
            OP_HEARTBEAT: begin
                if (tid < NUM_TASKS) seen_ms[tid] = now;
            end
            OP_CHECK: begin
                for (int i = NUM_TASKS - 1; i >= 0; i--) begin
                    age = now - seen_ms[i];
                    if (seen_ms[i] != '0 && age > task_age_limit(i))
                        st.stale_task = TASK_W'(i);
                end
                st.all_alive = (st.stale_task == NO_TASK);
                st.feed      = armed_now && st.all_alive;
                age          = now - boot_ms;
                if (st.feed && !healthy_now && age >= cfg_now.healthy_uptime) begin
                    healthy_now = 1'b1;
                    reboots     = '0;
                end
            end
            default: begin
            end
        endcase
        st.armed       = armed_now;
        st.wdt_reboots = reboots;
        st.healthy     = healthy_now;
        return st;
    endfunction

    task automatic note_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
        if (mismatch_count < REPORT_MAX)
            $display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, name, want, got);
        mismatch_count++;
    endtask

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_wd_status want;
        t_wd_status got;
        if (i_rst_n) begin
            if (in_valid && o_in_ready)
                status_q.push_back(supervise_step(in_opcode, in_task_id, in_now_ms, in_wdr));
            if (o_out_valid && out_ready) begin
                got = '{o_feed, o_armed, o_all_alive, o_stale_task, o_wdt_reboots,
                        o_healthy_reached};
                if (status_q.size() == 0) begin
                    note_field("result with nothing pending", '0, 32'(got));
                end else begin
                    want = status_q.pop_front();
                    if (got.feed != want.feed)
                        note_field("feed", 32'(want.feed), 32'(got.feed));
                    if (got.armed != want.armed)
                        note_field("armed", 32'(want.armed), 32'(got.armed));
                    if (got.all_alive != want.all_alive)
                        note_field("all_alive", 32'(want.all_alive), 32'(got.all_alive));
                    if (got.stale_task != want.stale_task)
                        note_field("stale_task", 32'(want.stale_task), 32'(got.stale_task));
                    if (got.wdt_reboots != want.wdt_reboots)
                        note_field("wdt_reboots", 32'(want.wdt_reboots),
                                   32'(got.wdt_reboots));
                    if (got.healthy != want.healthy)
                        note_field("healthy_reached", 32'(want.healthy), 32'(got.healthy));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            1: begin
                send_idle_pct  = 59;
                recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct  = 0;
                recv_stall_pct = 59;
            end
            default: begin
                send_idle_pct  = 15;
                recv_stall_pct = 15;
            end
        endcase
    endtask

    task automatic send_item(input logic [1:0] op, input logic [TASK_W-1:0] tid,
                             input logic [31:0] now, input logic wdr);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid   <= 1'b1;
        in_opcode  <= op;
        in_task_id <= tid;
        in_now_ms  <= now;
        in_wdr     <= wdr;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain_results;
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (status_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mask = (idx == REG_WDT_ENABLE) ? 32'h1 : (idx == REG_MAX_REBOOTS) ? 32'hFF : '1;
        if ((prdata & mask) != (value & mask))
            note_field("register readback", value & mask, prdata & mask);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_WDT_ENABLE:     cfg_now.wdt_enable     = value[0];
            REG_RADIO_STALE:    cfg_now.radio_stale    = value;
            REG_BEACON_STALE:   cfg_now.beacon_stale   = value;
            REG_POLL_STALE:     cfg_now.poll_stale     = value;
            REG_WEATHER_STALE:  cfg_now.weather_stale  = value;
            REG_CONSOLE_STALE:  cfg_now.console_stale  = value;
            REG_MAX_REBOOTS:    cfg_now.max_reboots    = value[7:0];
            REG_HEALTHY_UPTIME: cfg_now.healthy_uptime = value;
            default: begin
            end
        endcase
    endtask

    task automatic set_config(input logic en, input logic [31:0] radio,
                              input logic [31:0] beacon, input logic [31:0] poll,
                              input logic [31:0] weather, input logic [31:0] console,
                              input logic [7:0] max_boots, input logic [31:0] uptime);
        write_reg(REG_WDT_ENABLE, {31'd0, en});
        write_reg(REG_RADIO_STALE, radio);
        write_reg(REG_BEACON_STALE, beacon);
        write_reg(REG_POLL_STALE, poll);
        write_reg(REG_WEATHER_STALE, weather);
        write_reg(REG_CONSOLE_STALE, console);
        write_reg(REG_MAX_REBOOTS, {24'd0, max_boots});
        write_reg(REG_HEALTHY_UPTIME, uptime);
    endtask

    // aim three draws in ten at an age boundary or at the healthy uptime
    task automatic run_random(input int n);
        logic [1:0]        op;
        logic [TASK_W-1:0] tid;
        logic [31:0]       now;
        logic              wdr;
        int                r;
        int                pick;
        for (int k = 0; k < n; k++) begin
            r    = $urandom_range(99);
            tid  = TASK_W'($urandom_range(NUM_TASKS - 1));
            wdr  = 1'($urandom_range(1));
            pick = $urandom_range(NUM_TASKS - 1);
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: clock_ms = clock_ms + 32'($urandom_range(2000));
                6, 7: clock_ms = seen_ms[pick] + task_age_limit(pick)
                                 + 32'($urandom_range(2)) - 32'd1;
                8: clock_ms = boot_ms + cfg_now.healthy_uptime
                              + 32'($urandom_range(2)) - 32'd1;
                default: clock_ms = $urandom();
            endcase
            now = clock_ms;
            if (r < 8) begin
                op = OP_BOOT;
            end else if (r < 50) begin
                op = OP_HEARTBEAT;
            end else if (r < 92) begin
                op = OP_CHECK;
            end else begin
                op  = 2'($urandom_range(3));
                tid = TASK_W'($urandom_range(7));
                if (r < 95) now = '0;
                else now = $urandom();
            end
            send_item(op, tid, now, wdr);
        end
    endtask

    task automatic test_directed;
        set_idling(0);
        send_item(OP_CHECK, 3'd0, 32'd0, 1'b0);
        send_item(OP_RESERVED, 3'd5, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_HEARTBEAT, NO_TASK, 32'd1234, 1'b0);
        send_item(OP_BOOT, 3'd0, 32'd1000, 1'b1);
        for (int t = 0; t < NUM_TASKS; t++)
            send_item(OP_HEARTBEAT, TASK_W'(t), (t == 3) ? 32'd0 : 32'd1000, 1'b0);
        send_item(OP_CHECK, 3'd0, 32'd11000, 1'b0);
        send_item(OP_CHECK, 3'd0, 32'd11001, 1'b0);
        send_item(OP_CHECK, 3'd0, 32'd16001, 1'b0);
        send_item(OP_BOOT, 3'd0, 32'hFFFF_0000, 1'b1);
        send_item(OP_CHECK, 3'd0, 32'hFFFF_0000 + RST_HEALTHY_UPTIME - 32'd1, 1'b0);
        send_item(OP_CHECK, 3'd0, 32'hFFFF_0000 + RST_HEALTHY_UPTIME, 1'b0);
        send_item(OP_HEARTBEAT, 3'd2, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_CHECK, 3'd0, RST_BEACON_STALE - 32'd1, 1'b0);
        send_item(OP_CHECK, 3'd0, RST_BEACON_STALE, 1'b0);
        send_item(OP_BOOT, 3'd0, 32'd0, 1'b0);
        send_item(OP_HEARTBEAT, 3'd0, 32'd0, 1'b0);
        send_item(OP_CHECK, 3'd6, 32'hFFFF_FFFF, 1'b1);
        send_item(OP_RESERVED, 3'd0, 32'd0, 1'b0);
    endtask

    task automatic test_reboot_saturation;
        drain_results;
        set_config(1'b1, RST_RADIO_STALE, RST_BEACON_STALE, RST_POLL_STALE,
                   RST_WEATHER_STALE, RST_CONSOLE_STALE, COUNT_MAX - 8'd1,
                   RST_HEALTHY_UPTIME);
        set_idling(3);
        for (int k = 0; k < 260; k++) begin
            send_item(OP_BOOT, TASK_W'(k), 32'(k * 1000 + 1), 1'b1);
            if (k % 16 == 0) send_item(OP_CHECK, 3'd0, 32'(k * 1000 + 5), 1'b0);
        end
        send_item(OP_CHECK, 3'd0, 32'd300000, 1'b0);
        send_item(OP_BOOT, 3'd0, 32'd7, 1'b0);
    endtask

    task automatic test_config_sweep;
        for (int s = 0; s < 5; s++) begin
            drain_results;
            set_idling(s % 4);
            case (s)
                0: set_config(1'b0, '0, '0, '0, '0, '0, '0, '0);
                1: set_config(1'b1, '1, '1, '1, '1, '1, COUNT_MAX, '1);
                2: set_config(1'b1, $urandom_range(1, 5000), $urandom_range(1, 5000),
                              $urandom_range(1, 5000), $urandom_range(1, 5000),
                              $urandom_range(1, 5000), 8'($urandom_range(6)),
                              $urandom_range(20000));
                3: set_config(1'($urandom_range(1)), $urandom(), $urandom(), $urandom(),
                              $urandom(), $urandom(), 8'($urandom()), $urandom());
                default: set_config(1'b1, RST_RADIO_STALE, RST_BEACON_STALE,
                                    RST_POLL_STALE, RST_WEATHER_STALE, RST_CONSOLE_STALE,
                                    RST_MAX_REBOOTS, RST_HEALTHY_UPTIME);
            endcase
            run_random(70);
        end
    endtask

    task automatic test_random_traffic;
        drain_results;
        set_config(1'b1, 32'd6000, 32'd3000, 32'd2500, 32'd4000, 32'd1500, 8'd3,
                   32'd9000);
        for (int m = 0; m < 4; m++) begin
            set_idling(m);
            run_random(55);
            drain_results;
            run_random(55);
        end
    endtask

    initial begin
        cfg_now = '{1'b1, RST_RADIO_STALE, RST_BEACON_STALE, RST_POLL_STALE,
                    RST_WEATHER_STALE, RST_CONSOLE_STALE, RST_MAX_REBOOTS,
                    RST_HEALTHY_UPTIME};
        for (int i = 0; i < NUM_TASKS; i++) seen_ms[i] = '0;
        reboots     = '0;
        armed_now   = 1'b0;
        boot_ms     = '0;
        healthy_now = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed;
        test_reboot_saturation;
        test_config_sweep;
        test_random_traffic;
        drain_results;

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
